// ===== design/rrpt_pkg.sv =====
// Shared types and codes for the round-robin process table.
// Beat payload structs, action and status codes. No dependencies.
package rrpt_pkg;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_SET_CUR  = 3'd1,
    ACT_GET_CUR  = 3'd2,
    ACT_GET_SLOT = 3'd3,
    ACT_GET_NEXT = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_NONE  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_RESP = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  slot_id;
    logic [31:0] entry_data;
  } rrpt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [31:0] entry_out;
  } rrpt_out_t;

endpackage

// ===== design/rrpt_mem.sv =====
// Entry word store: single-port synchronous RAM with registered read.
// No package dependency.
module rrpt_mem #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rrpt_search.sv =====
// Circular next-used-slot finder over the used flags.
// Picks the lowest used slot above the start, else wraps to the lowest used slot.
module rrpt_search #(
  parameter int Slots = 16
) (
  input  logic [Slots-1:0]         used_i,
  input  logic [$clog2(Slots)-1:0] start_i,
  output logic                     found_o,
  output logic [$clog2(Slots)-1:0] next_o
);

  localparam int SlotW = $clog2(Slots);

  logic             hi_found;
  logic [SlotW-1:0] hi_idx;
  logic [SlotW-1:0] lo_idx;

  always_comb begin
    hi_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (used_i[i]) begin
        lo_idx = SlotW'(i);
        if (SlotW'(i) > start_i) begin
          hi_idx   = SlotW'(i);
          hi_found = 1'b1;
        end
      end
    end
  end

  assign found_o = |used_i;
  assign next_o  = hi_found ? hi_idx : lo_idx;

endmodule

// ===== design/round_robin_process_table.sv =====
// Round-robin process table: used flags in flops, entry words in a registered-read RAM.
// An accepted beat's decision and RAM read are registered, then its result is loaded
// into the output register, held there while the receiver stalls. A new beat is only
// accepted once the previous result has been loaded into the output register.
// Reset: used flags, current pointer and control clear at once; entry RAM has no
// reset and is only read for slots marked used.
module round_robin_process_table
  import rrpt_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rrpt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rrpt_out_t out_data_o
);

  localparam int SlotW  = $clog2(SLOTS);
  localparam int StoreW = (ENTRY_WIDTH < 32) ? ENTRY_WIDTH : 32;

  fsm_e state_q, state_d;

  logic [SLOTS-1:0]  used_q, used_d;
  logic [SlotW-1:0]  cur_slot_q, cur_slot_d;
  logic              cur_valid_q, cur_valid_d;

  logic [1:0]        status_q;
  logic [SlotW-1:0]  slot_q;
  logic              is_add_q;
  logic [StoreW-1:0] data_q;

  logic              out_valid_q, out_valid_d;
  rrpt_out_t         out_q;

  logic              in_fire;
  logic              out_load;

  logic [SlotW-1:0]  idx;
  logic              in_range;
  logic              found;
  logic [SlotW-1:0]  next_idx;

  logic [1:0]        status_d;
  logic [SlotW-1:0]  target;
  logic              do_write;
  logic              do_read;
  logic [StoreW-1:0] rdata;

  assign idx      = in_data_i.slot_id[SlotW-1:0];
  assign in_range = {1'b0, in_data_i.slot_id} < 7'(SLOTS);
  assign in_fire  = in_valid_i && !in_stall_o;

  rrpt_search #(
    .Slots(SLOTS)
  ) u_search (
    .used_i (used_q),
    .start_i(idx),
    .found_o(found),
    .next_o (next_idx)
  );

  // Decision on the accept cycle: status, target slot and state updates.
  always_comb begin
    status_d    = ST_NONE;
    target      = idx;
    do_write    = 1'b0;
    used_d      = used_q;
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    unique case (in_data_i.action)
      ACT_ADD: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (used_q[idx]) begin
          status_d = ST_DUP;
        end else begin
          status_d = ST_OK;
          do_write = 1'b1;
          used_d[idx] = 1'b1;
          if (!cur_valid_q) begin
            cur_slot_d  = idx;
            cur_valid_d = 1'b1;
          end
        end
      end
      ACT_SET_CUR: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (used_q[idx]) begin
          status_d    = ST_OK;
          cur_slot_d  = idx;
          cur_valid_d = 1'b1;
        end
      end
      ACT_GET_CUR: begin
        if (cur_valid_q) begin
          status_d = ST_OK;
          target   = cur_slot_q;
        end
      end
      ACT_GET_SLOT: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (used_q[idx]) begin
          status_d = ST_OK;
        end
      end
      ACT_GET_NEXT: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (used_q[idx] && found) begin
          status_d = ST_OK;
          target   = next_idx;
        end
      end
      default: begin
        status_d = ST_NONE;
      end
    endcase
  end

  assign do_read = (status_d == ST_OK) && !do_write;

  rrpt_mem #(
    .Depth(SLOTS),
    .Width(StoreW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (in_fire && do_write),
    .re_i   (in_fire && do_read),
    .addr_i (target),
    .wdata_i(in_data_i.entry_data[StoreW-1:0]),
    .rdata_o(rdata)
  );

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (in_fire) state_d = FSM_RESP;
      FSM_RESP: if (out_load) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      FSM_IDLE: in_stall_o = 1'b0;
      FSM_RESP: out_load = !out_valid_q || !out_stall_i;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      used_q      <= '0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        used_q      <= used_d;
        cur_slot_q  <= cur_slot_d;
        cur_valid_q <= cur_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      slot_q   <= target;
      is_add_q <= do_write;
      data_q   <= in_data_i.entry_data[StoreW-1:0];
    end
    if (out_load) begin
      out_q.status <= status_q;
      if (status_q == ST_OK) begin
        out_q.slot_out  <= 6'(slot_q);
        out_q.entry_out <= is_add_q ? 32'(data_q) : 32'(rdata);
      end else begin
        out_q.slot_out  <= '0;
        out_q.entry_out <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Only one item in flight: an accepted beat closes the input next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // Once a slot is current, some slot stays current.
  a_cur_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |=> cur_valid_q)
    else $error("current pointer lost");

  // A successful result always names a used slot.
  a_ok_is_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_OK) |->
      used_q[out_data_o.slot_out[SlotW-1:0]])
    else $error("ok result for an unused slot");

  // Error results carry zero slot and entry.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |->
      (out_data_o.slot_out == '0 && out_data_o.entry_out == '0))
    else $error("error result with nonzero payload");

endmodule

// ===== sim/round_robin_process_table_tb.sv =====
// Testbench for round_robin_process_table: directed and random scheduler calls.
// Checks every result beat against an in-bench table predictor.
// Depends on rrpt_pkg and the round_robin_process_table RTL.
`timescale 1ns / 100ps

module round_robin_process_table_tb
  import rrpt_pkg::*;
();

  localparam int SLOTS       = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1880;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_SQUARE,
    STALL_HEAVY
  } stall_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  rrpt_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rrpt_out_t out_data;

  // predictor state
  logic [31:0] table_entry [SLOTS];
  bit          table_used  [SLOTS];
  logic [5:0]  table_cur;
  bit          table_cur_valid;

  rrpt_out_t   expected_replies[$];
  int          error_count = 0;
  int          burst_left  = 0;

  stall_mode_e stall_mode  = STALL_NONE;
  logic [5:0]  stall_phase = '0;

  round_robin_process_table #(
    .SLOTS       (SLOTS),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rrpt_out_t slot_reply(input logic [5:0] slot);
    rrpt_out_t r;
    r.status    = ST_OK;
    r.slot_out  = slot;
    r.entry_out = table_entry[slot];
    return r;
  endfunction

  // Applies one scheduler call to the predicted table and returns its reply.
  function automatic rrpt_out_t table_reply(input rrpt_in_t beat);
    rrpt_out_t r;
    bit        in_range;
    int        idx;
    r        = '0;
    r.status = ST_NONE;
    in_range = beat.slot_id < SLOTS;
    case (beat.action)
      ACT_ADD: begin
        if (!in_range) r.status = ST_RANGE;
        else if (table_used[beat.slot_id]) r.status = ST_DUP;
        else begin
          table_entry[beat.slot_id] = beat.entry_data;
          table_used[beat.slot_id]  = 1'b1;
          if (!table_cur_valid) begin
            table_cur       = beat.slot_id;
            table_cur_valid = 1'b1;
          end
          r = slot_reply(beat.slot_id);
        end
      end
      ACT_SET_CUR: begin
        if (!in_range) r.status = ST_RANGE;
        else if (table_used[beat.slot_id]) begin
          table_cur       = beat.slot_id;
          table_cur_valid = 1'b1;
          r = slot_reply(beat.slot_id);
        end
      end
      ACT_GET_CUR: begin
        if (table_cur_valid && table_cur < SLOTS) r = slot_reply(table_cur);
      end
      ACT_GET_SLOT: begin
        if (!in_range) r.status = ST_RANGE;
        else if (table_used[beat.slot_id]) r = slot_reply(beat.slot_id);
      end
      ACT_GET_NEXT: begin
        if (!in_range) r.status = ST_RANGE;
        else if (table_used[beat.slot_id]) begin
          // circular search, may land on the starting slot itself
          for (int k = SLOTS; k >= 1; k--) begin
            idx = (beat.slot_id + k) % SLOTS;
            if (table_used[idx]) r = slot_reply(idx[5:0]);
          end
        end
      end
      default: r.status = ST_NONE;
    endcase
    return r;
  endfunction

  // Sends one beat; the sender may idle between bursts of random length.
  task automatic send_call(input logic [2:0] act, input logic [5:0] slot,
                           input logic [31:0] data);
    rrpt_in_t beat;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    beat.action     = act;
    beat.slot_id    = slot;
    beat.entry_data = data;
    expected_replies.push_back(table_reply(beat));
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stall: picks a random pattern each time the 6-bit phase counter wraps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_phase <= '0;
      stall_mode  <= STALL_NONE;
    end else begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == '0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_SQUARE: out_stall <= stall_phase[2];
        default:      out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    rrpt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result beat status=%0d slot=%0d entry=%h",
                   $time, out_data.status, out_data.slot_out, out_data.entry_out);
      end else begin
        want = expected_replies.pop_front();
        if (out_data.status !== want.status || out_data.slot_out !== want.slot_out ||
            out_data.entry_out !== want.entry_out) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch exp status=%0d slot=%0d entry=%h, got %0d %0d %h",
                     $time, want.status, want.slot_out, want.entry_out,
                     out_data.status, out_data.slot_out, out_data.entry_out);
        end
      end
    end
  end

  // Empty table: every lookup misses, bad ids and unknown actions rejected.
  task automatic test_empty_table();
    send_call(ACT_GET_CUR, 6'd0, 32'h0);
    send_call(ACT_GET_SLOT, 6'd0, 32'h0);
    send_call(ACT_GET_NEXT, 6'd0, 32'h0);
    send_call(ACT_SET_CUR, 6'd5, 32'h0);
    send_call(ACT_GET_SLOT, 6'd16, 32'h0);
    send_call(ACT_GET_NEXT, 6'd63, 32'h0);
    send_call(ACT_SET_CUR, 6'd16, 32'h0);
    for (int a = ACT_UNKNOWN_LO; a <= ACT_UNKNOWN_HI; a++)
      send_call(a[2:0], 6'd63, 32'hFFFF_FFFF);
  endtask

  // Adds, duplicates, wrap of get-next and moving the current pointer.
  task automatic test_add_and_lookup();
    send_call(ACT_ADD, 6'd7, 32'hA5A5_5A5A);      // first add becomes current
    send_call(ACT_GET_NEXT, 6'd7, 32'h0);         // lone slot finds itself
    send_call(ACT_ADD, 6'd0, 32'h0000_0000);
    send_call(ACT_ADD, 6'd15, 32'hFFFF_FFFF);
    send_call(ACT_ADD, 6'd0, 32'h1234_5678);      // duplicate
    send_call(ACT_ADD, 6'd16, 32'h1);
    send_call(ACT_ADD, 6'd63, 32'h1);
    send_call(ACT_GET_CUR, 6'd0, 32'h0);
    send_call(ACT_GET_NEXT, 6'd7, 32'h0);
    send_call(ACT_GET_NEXT, 6'd15, 32'h0);        // wraps to slot 0
    send_call(ACT_SET_CUR, 6'd15, 32'h0);
    send_call(ACT_SET_CUR, 6'd3, 32'h0);          // unused, pointer stays
    send_call(ACT_GET_CUR, 6'd0, 32'h0);
    send_call(ACT_GET_SLOT, 6'd15, 32'h0);
  endtask

  // Random calls; lookups lean toward used slots so hits dominate.
  task automatic test_random_traffic();
    logic [2:0] act;
    logic [5:0] slot;
    int         roll;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) act = ACT_ADD;
      else if (roll < 20) act = ACT_SET_CUR;
      else if (roll < 35) act = ACT_GET_CUR;
      else if (roll < 60) act = ACT_GET_SLOT;
      else if (roll < 93) act = ACT_GET_NEXT;
      else act = 3'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
      if ($urandom_range(0, 99) < 12) slot = 6'($urandom_range(SLOTS, 63));
      else begin
        slot = 6'($urandom_range(0, SLOTS - 1));
        if (act != ACT_ADD && $urandom_range(0, 9) < 6)
          for (int k = 0; k < SLOTS; k++)
            if (!table_used[slot]) slot = 6'((slot + 1) % SLOTS);
      end
      send_call(act, slot, $urandom());
    end
  endtask

  initial begin
    int wait_cycles;
    foreach (table_used[i]) table_used[i] = 1'b0;
    table_cur       = '0;
    table_cur_valid = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_and_lookup();
    test_random_traffic();

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_replies.size() != 0 && wait_cycles < 4000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (16) @(posedge clk);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rrpt_pkg.sv
design/rrpt_mem.sv
design/rrpt_search.sv
design/round_robin_process_table.sv
sim/round_robin_process_table_tb.sv
